[sv/csvtok_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvtok_pkg
// Shared constants and types of the CSV field tokenizer.
// ----------------------------------------------------------------------------
package csvtok_pkg;

  localparam int unsigned COL_BITS_DEFAULT = 8;
  localparam int unsigned ROW_BITS_DEFAULT = 16;

  // field widths on the stream ports
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COLUMN_W = 8;
  localparam int unsigned ROW_W    = 16;
  localparam int unsigned OUT_W    = BYTE_W + COLUMN_W + ROW_W;

  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2
  } kind_t;

endpackage

[sv/csv_field_tokenizer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_tokenizer_unit
// Splits a CSV byte stream into content bytes, field ends and row ends.
// Each accepted byte is registered in the input stage, and its result in the result stage.
// Throughput: one byte per cycle while the result is not stalled, through the input and result stages.
// Bytes that give no result (carriage return, quote) still take one slot.
// Reset: rst clears both stage valids, quote state and column/row counters.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_unit #(
  parameter int unsigned COL_BITS = csvtok_pkg::COL_BITS_DEFAULT,
  parameter int unsigned ROW_BITS = csvtok_pkg::ROW_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [csvtok_pkg::BYTE_W-1:0] s_tdata,   // byte_in
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [csvtok_pkg::OUT_W-1:0]  m_tdata,   // data_byte, column, row
  output logic [1:0]                    m_tuser    // kind
);

  localparam int unsigned COL_EXT = (COL_BITS > csvtok_pkg::COLUMN_W) ?
                                    COL_BITS : csvtok_pkg::COLUMN_W;
  localparam int unsigned ROW_EXT = (ROW_BITS > csvtok_pkg::ROW_W) ?
                                    ROW_BITS : csvtok_pkg::ROW_W;
  localparam logic [COL_BITS-1:0] COL_MAX = {COL_BITS{1'b1}};
  localparam logic [ROW_BITS-1:0] ROW_MAX = {ROW_BITS{1'b1}};

  // input stage
  logic                          in_valid;
  logic [csvtok_pkg::BYTE_W-1:0] in_byte;

  // tokenizer state
  logic                in_quotes, in_quotes_next;
  logic                quote_pending, quote_pending_next;
  logic [COL_BITS-1:0] column_count, column_count_next;
  logic [ROW_BITS-1:0] row_count, row_count_next;

  logic                          emit;
  csvtok_pkg::kind_t             kind;
  logic [csvtok_pkg::BYTE_W-1:0] data_byte;
  logic                          quoted;
  logic                          advance;
  logic [COL_EXT-1:0]            col_ext;
  logic [ROW_EXT-1:0]            row_ext;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  assign col_ext = COL_EXT'(column_count);
  assign row_ext = ROW_EXT'(row_count);

  always_comb begin
    emit               = 1'b0;
    kind               = csvtok_pkg::KIND_DATA;
    data_byte          = in_byte;
    in_quotes_next     = in_quotes;
    quote_pending_next = 1'b0;
    column_count_next  = column_count;
    row_count_next     = row_count;
    // a held quote followed by anything but a quote closed the section
    quoted = in_quotes && !quote_pending;
    if (quote_pending && in_byte != csvtok_pkg::CH_QUOTE) begin
      in_quotes_next = 1'b0;
    end
    priority if (quote_pending && in_byte == csvtok_pkg::CH_QUOTE) begin
      emit = 1'b1;
    end else if (in_byte == csvtok_pkg::CH_CR) begin
      emit = 1'b0;
    end else if (in_byte == csvtok_pkg::CH_LF) begin
      emit              = 1'b1;
      kind              = csvtok_pkg::KIND_ROW;
      data_byte         = '0;
      column_count_next = '0;
      in_quotes_next    = 1'b0;
      if (row_count != ROW_MAX) begin
        row_count_next = row_count + ROW_BITS'(1);
      end
    end else if (in_byte == csvtok_pkg::CH_QUOTE) begin
      if (quoted) begin
        quote_pending_next = 1'b1;
      end else begin
        in_quotes_next = 1'b1;
      end
    end else if (in_byte == csvtok_pkg::CH_COMMA && !quoted) begin
      emit      = 1'b1;
      kind      = csvtok_pkg::KIND_FIELD;
      data_byte = '0;
      if (column_count != COL_MAX) begin
        column_count_next = column_count + COL_BITS'(1);
      end
    end else begin
      emit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_tvalid      <= 1'b0;
      in_quotes     <= 1'b0;
      quote_pending <= 1'b0;
      column_count  <= '0;
      row_count     <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
        in_byte  <= s_tdata;
      end
      if (advance) begin
        m_tvalid <= in_valid && emit;
        if (in_valid) begin
          in_quotes     <= in_quotes_next;
          quote_pending <= quote_pending_next;
          column_count  <= column_count_next;
          row_count     <= row_count_next;
          m_tdata       <= {row_ext[csvtok_pkg::ROW_W-1:0],
                            col_ext[csvtok_pkg::COLUMN_W-1:0], data_byte};
          m_tuser       <= kind;
        end
      end
    end
  end

endmodule

[sv/csvtok_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvtok_checker
// Port-level checks of the CSV field tokenizer, bound to the tokenizer unit.
// ----------------------------------------------------------------------------
module csvtok_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [csvtok_pkg::OUT_W-1:0]  m_tdata,
  input logic [1:0]                    m_tuser
);

  // a stalled result transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == csvtok_pkg::KIND_DATA || m_tuser == csvtok_pkg::KIND_FIELD ||
                  m_tuser == csvtok_pkg::KIND_ROW))
    else $error("illegal kind");

  // boundary markers carry no content byte
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != csvtok_pkg::KIND_DATA |-> m_tdata[csvtok_pkg::BYTE_W-1:0] == '0)
    else $error("boundary with nonzero data");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("valid after reset");

endmodule

bind csv_field_tokenizer_unit csvtok_checker u_csvtok_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CSV field tokenizer. Bytes of generated CSV
// text go in on the input stream, and a scoreboard tracks quote and
// column/row state to predict each content byte, field end and row end.
// Every output transaction is checked field by field against the oldest
// prediction. The run uses mixed sender and receiver idling, one long
// output hold-off and a very long row for column saturation.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned PHASE_BYTES  = 330;
  localparam int unsigned LONG_FIELDS  = 260;

  typedef struct packed {
    logic [csvtok_pkg::BYTE_W-1:0]   data_byte;
    csvtok_pkg::kind_t               kind;
    logic [csvtok_pkg::COLUMN_W-1:0] column;
    logic [csvtok_pkg::ROW_W-1:0]    row;
  } token_t;

  class tokenizer_scoreboard;
    bit                              in_quotes;
    bit                              quote_pending;
    logic [csvtok_pkg::COLUMN_W-1:0] col_idx;
    logic [csvtok_pkg::ROW_W-1:0]    row_idx;
    token_t                          pending_tokens[$];
    int                              errors;
    int                              checked;
    int                              bytes_in;

    task report(string what);
      errors++;
      $display("mismatch %0d at %0t ns: %s", errors, $time, what);
    endtask

    function void push_token(logic [csvtok_pkg::BYTE_W-1:0] b, csvtok_pkg::kind_t k);
      token_t t;
      t.data_byte = b;
      t.kind      = k;
      t.column    = col_idx;
      t.row       = row_idx;
      pending_tokens = {pending_tokens, t};
    endfunction

    // predict the token (if any) caused by one accepted byte
    function void note_byte(logic [csvtok_pkg::BYTE_W-1:0] c);
      bytes_in++;
      if (quote_pending) begin
        quote_pending = 1'b0;
        if (c == csvtok_pkg::CH_QUOTE) begin
          push_token(csvtok_pkg::CH_QUOTE, csvtok_pkg::KIND_DATA);
          return;
        end
        in_quotes = 1'b0;
      end
      if (c == csvtok_pkg::CH_CR)
        return;
      if (c == csvtok_pkg::CH_LF) begin
        push_token('0, csvtok_pkg::KIND_ROW);
        col_idx = '0;
        if (row_idx != '1)
          row_idx++;
        in_quotes = 1'b0;
        return;
      end
      if (c == csvtok_pkg::CH_QUOTE) begin
        if (in_quotes)
          quote_pending = 1'b1;
        else
          in_quotes = 1'b1;
        return;
      end
      if (c == csvtok_pkg::CH_COMMA && !in_quotes) begin
        push_token('0, csvtok_pkg::KIND_FIELD);
        if (col_idx != '1)
          col_idx++;
        return;
      end
      push_token(c, csvtok_pkg::KIND_DATA);
    endfunction

    task check_token(token_t got);
      token_t want;
      if (pending_tokens.size() == 0) begin
        report($sformatf("unexpected token kind=%0d byte=%02h col=%0d row=%0d",
                         got.kind, got.data_byte, got.column, got.row));
        return;
      end
      want = pending_tokens.pop_front();
      checked++;
      if (got.kind !== want.kind)
        report($sformatf("token %0d kind %0d, wanted %0d", checked, got.kind, want.kind));
      if (got.data_byte !== want.data_byte)
        report($sformatf("token %0d byte %02h, wanted %02h", checked, got.data_byte,
                         want.data_byte));
      if (got.column !== want.column)
        report($sformatf("token %0d column %0d, wanted %0d", checked, got.column,
                         want.column));
      if (got.row !== want.row)
        report($sformatf("token %0d row %0d, wanted %0d", checked, got.row, want.row));
    endtask
  endclass

  logic                             clk;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [csvtok_pkg::BYTE_W-1:0]    s_tdata;    // byte_in
  logic                             m_tvalid;
  logic                             m_tready;
  logic [csvtok_pkg::OUT_W-1:0]     m_tdata;    // data_byte, column, row
  logic [1:0]                       m_tuser;    // kind

  tokenizer_scoreboard              board;
  logic [csvtok_pkg::BYTE_W-1:0]    text_q[$];
  int unsigned                      src_idle_pct;
  int unsigned                      sink_stall_pct;
  int unsigned                      hold_left;
  int unsigned                      cycle_count;
  int unsigned                      phase_bytes;

  csv_field_tokenizer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // receiver: long hold-off first, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    token_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.data_byte = m_tdata[csvtok_pkg::BYTE_W-1:0];
      got.column    = m_tdata[csvtok_pkg::BYTE_W +: csvtok_pkg::COLUMN_W];
      got.row       = m_tdata[csvtok_pkg::BYTE_W+csvtok_pkg::COLUMN_W +: csvtok_pkg::ROW_W];
      got.kind      = csvtok_pkg::kind_t'(m_tuser);
      board.check_token(got);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d tokens outstanding", cycle_count,
             board.pending_tokens.size());
    $display("Regression FAIL");
    $finish;
  end

  function automatic void queue_byte(input logic [csvtok_pkg::BYTE_W-1:0] b);
    text_q = {text_q, b};
  endfunction

  // one byte per transaction, called and returning at a falling edge
  task automatic send_byte(input logic [csvtok_pkg::BYTE_W-1:0] b);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    board.note_byte(b);
    phase_bytes++;
    @(negedge clk);
  endtask

  task automatic send_text();
    while (text_q.size() != 0)
      send_byte(text_q.pop_front());
  endtask

  function automatic logic [csvtok_pkg::BYTE_W-1:0] plain_byte();
    logic [csvtok_pkg::BYTE_W-1:0] b;
    do
      b = csvtok_pkg::BYTE_W'($urandom_range(255));
    while (b == csvtok_pkg::CH_QUOTE || b == csvtok_pkg::CH_COMMA ||
           b == csvtok_pkg::CH_CR || b == csvtok_pkg::CH_LF);
    return b;
  endfunction

  // well-formed row with random content; quoted fields may hold commas,
  // escaped quotes, carriage returns and the odd newline
  task automatic add_row(input int unsigned fields);
    int unsigned len;
    int unsigned r;
    for (int unsigned f = 0; f < fields; f++) begin
      if (f > 0)
        queue_byte(csvtok_pkg::CH_COMMA);
      len = $urandom_range(6);
      if ($urandom_range(1) == 1) begin
        queue_byte(csvtok_pkg::CH_QUOTE);
        for (int unsigned i = 0; i < len; i++) begin
          r = $urandom_range(99);
          if (r < 8)
            queue_byte(csvtok_pkg::CH_COMMA);
          else if (r < 10)
            queue_byte(csvtok_pkg::CH_CR);
          else if (r < 12)
            queue_byte(csvtok_pkg::CH_LF);
          else if (r < 22) begin
            queue_byte(csvtok_pkg::CH_QUOTE);
            queue_byte(csvtok_pkg::CH_QUOTE);
          end else
            queue_byte(plain_byte());
        end
        queue_byte(csvtok_pkg::CH_QUOTE);
        // stray text after a closing quote
        if ($urandom_range(9) == 0)
          queue_byte(plain_byte());
      end else begin
        for (int unsigned i = 0; i < len; i++)
          queue_byte(plain_byte());
      end
    end
    if ($urandom_range(2) == 0)
      queue_byte(csvtok_pkg::CH_CR);
    queue_byte(csvtok_pkg::CH_LF);
  endtask

  task automatic add_noise();
    logic [csvtok_pkg::BYTE_W-1:0] specials[4];
    int unsigned                   len;
    specials = '{csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_COMMA, csvtok_pkg::CH_CR,
                 csvtok_pkg::CH_LF};
    len = $urandom_range(12, 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < 40)
        queue_byte(specials[$urandom_range(3)]);
      else
        queue_byte(csvtok_pkg::BYTE_W'($urandom_range(255)));
    end
  endtask

  task automatic random_text(input int unsigned nbytes);
    phase_bytes = 0;
    while (phase_bytes < nbytes) begin
      if ($urandom_range(9) == 0)
        add_noise();
      else
        add_row($urandom_range(6, 1));
      send_text();
    end
  endtask

  initial begin
    int unsigned src_mix[4];
    int unsigned sink_mix[4];
    src_mix  = '{0, 65, 0, 21};
    sink_mix = '{0, 0, 65, 21};
    board = new();
    cycle_count    = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_left      = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extreme bytes, escaped quote, closing quote before comma,
    // newline inside quotes, empty line, closing quote resolved by cr and lf
    text_q = '{8'h00, 8'hFF, csvtok_pkg::CH_COMMA, csvtok_pkg::CH_QUOTE,
               csvtok_pkg::CH_COMMA, csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_QUOTE, 8'h41,
               csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_COMMA, csvtok_pkg::CH_QUOTE,
               csvtok_pkg::CH_LF, csvtok_pkg::CH_LF, csvtok_pkg::CH_QUOTE,
               csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_CR, csvtok_pkg::CH_CR, 8'h7A,
               csvtok_pkg::CH_QUOTE, 8'h71, csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_LF};
    send_text();
    s_tvalid <= 1'b0;

    // output held off while input keeps coming, so the block backs up
    @(posedge clk);
    hold_left = 400;
    @(negedge clk);
    while (text_q.size() < 100)
      add_row($urandom_range(5, 1));
    send_text();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (hold_left != 0)
      @(negedge clk);

    // long row of empty fields drives the column count into saturation
    for (int unsigned i = 0; i < LONG_FIELDS; i++)
      queue_byte(csvtok_pkg::CH_COMMA);
    queue_byte(csvtok_pkg::CH_LF);
    send_text();

    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = src_mix[p];
      sink_stall_pct = sink_mix[p];
      random_text(PHASE_BYTES);
    end

    src_idle_pct   = 21;
    sink_stall_pct = 21;
    random_text(100);
    s_tvalid <= 1'b0;

    while (board.pending_tokens.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("bytes sent: %0d, tokens checked: %0d, cycles: %0d", board.bytes_in,
             board.checked, cycle_count);
    $display("quoted/escaped text, noise, output hold-off, column saturation");
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[csv_field_tokenizer_unit.f]
sv/csvtok_pkg.sv
sv/csv_field_tokenizer_unit.sv
sv/csvtok_checker.sv
test/tb_top.sv
